/* rtl/vt4_pkg.sv */
package vt4_pkg;

	localparam int FracBitsDefault = 16;
	localparam int NumRegs = 8;
	localparam int CfgAddrW = 3;
	localparam int CfgDataW = 64;
	localparam int FixW = 32;
	localparam int ProdW = 2 * FixW;
	localparam int PairW = ProdW + 1;
	localparam int SumW = ProdW + 2;

	typedef logic [CfgAddrW-1:0] cfg_addr_t;
	typedef logic [CfgDataW-1:0] cfg_word_t;
	typedef logic [FixW-1:0] fix_t;
	typedef fix_t [3:0] row_t;
	typedef row_t [3:0] mat_t;
	typedef logic signed [SumW-1:0] sum_t;

	localparam cfg_word_t CfgReset [NumRegs] = '{
		64'h0001_0000_0000_0000,
		64'h0000_0000_0000_0000,
		64'h0000_0000_0001_0000,
		64'h0000_0000_0000_0000,
		64'h0000_0000_0000_0000,
		64'h0001_0000_0000_0000,
		64'h0000_0000_0000_0000,
		64'h0000_0000_0001_0000
	};

	typedef struct packed {
		logic signed [FixW-1:0] vec_x;
		logic signed [FixW-1:0] vec_y;
		logic signed [FixW-1:0] vec_z;
		logic signed [FixW-1:0] vec_w;
	} in_t;

	typedef struct packed {
		logic signed [FixW-1:0] out_x;
		logic signed [FixW-1:0] out_y;
		logic signed [FixW-1:0] out_z;
		logic signed [FixW-1:0] out_w;
		logic clipped;
	} out_t;

	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
	} stage_en_t;

endpackage

/* rtl/vt4_cfg.sv */
module vt4_cfg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  vt4_pkg::cfg_addr_t  cfg_addr,
	input  vt4_pkg::cfg_word_t  cfg_data,
	output vt4_pkg::mat_t       mat
);

	vt4_pkg::cfg_word_t regs_q [vt4_pkg::NumRegs];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < vt4_pkg::NumRegs; i++) begin
				regs_q[i] <= vt4_pkg::CfgReset[i];
			end
		end else if (cfg_we) begin
			regs_q[cfg_addr] <= cfg_data;
		end
	end

	// Each row uses two registers; the left column of a pair sits in the high half.
	for (genvar r = 0; r < 4; r++) begin : g_row
		for (genvar c = 0; c < 4; c++) begin : g_col
			localparam int RegIdx = 2 * r + c / 2;
			if (c % 2 == 0) begin : g_hi
				assign mat[r][c] = regs_q[RegIdx][63:32];
			end else begin : g_lo
				assign mat[r][c] = regs_q[RegIdx][31:0];
			end
		end
	end

endmodule

/* rtl/vt4_row_dot.sv */
module vt4_row_dot (
	input  logic                clk,
	input  vt4_pkg::stage_en_t  en,
	input  vt4_pkg::row_t       row,
	input  vt4_pkg::in_t        vec,
	output vt4_pkg::sum_t       sum_s3
);

	logic signed [vt4_pkg::FixW-1:0] comp [4];
	logic signed [vt4_pkg::ProdW-1:0] prod_s1 [4];
	logic signed [vt4_pkg::PairW-1:0] pair_s2 [2];

	assign comp[0] = vec.vec_x;
	assign comp[1] = vec.vec_y;
	assign comp[2] = vec.vec_z;
	assign comp[3] = vec.vec_w;

	always_ff @(posedge clk) begin
		if (en.s1) begin
			for (int c = 0; c < 4; c++) begin
				prod_s1[c] <= $signed(row[c]) * comp[c];
			end
		end
		if (en.s2) begin
			pair_s2[0] <= vt4_pkg::PairW'(prod_s1[0]) + vt4_pkg::PairW'(prod_s1[1]);
			pair_s2[1] <= vt4_pkg::PairW'(prod_s1[2]) + vt4_pkg::PairW'(prod_s1[3]);
		end
		if (en.s3) begin
			sum_s3 <= vt4_pkg::SumW'(pair_s2[0]) + vt4_pkg::SumW'(pair_s2[1]);
		end
	end

endmodule

/* rtl/vertex_transform_4x4.sv */
// Transforms a stream of homogeneous vectors by a 4x4 signed fixed-point matrix.
// The matrix sits in eight 64-bit registers, two entries per register, written
// through cfg_we, cfg_addr and cfg_data; write them only while no item is in flight.
// An item enters on vec when vec_valid and vec_ready are both high and leaves on res
// when res_valid and res_ready are both high. Each output component is a row of the
// matrix dotted with the vector, summed exactly, shifted right by FRAC_BITS with
// rounding toward minus infinity and saturated to 32 bits; clipped flags saturation.
// The pipeline has four register stages: the sixteen products, the pair sums, the
// row sums, and the shifted and saturated result in the output register. An item
// passes through these stages in order, and one item is accepted every cycle while
// the receiver keeps up. When res_ready is low, each stage still accepts an item as
// long as the stage after it is empty or moving, so bubbles close up and up to four
// items wait in the block without loss. Reset empties the pipeline and loads the
// identity matrix (for sixteen fraction bits).
module vertex_transform_4x4 #(
	parameter int FRAC_BITS = vt4_pkg::FracBitsDefault
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  vt4_pkg::cfg_addr_t  cfg_addr,
	input  vt4_pkg::cfg_word_t  cfg_data,
	input  logic                vec_valid,
	output logic                vec_ready,
	input  vt4_pkg::in_t        vec,
	output logic                res_valid,
	input  logic                res_ready,
	output vt4_pkg::out_t       res
);

	localparam vt4_pkg::sum_t SatMax = vt4_pkg::SumW'(64'sd2147483647);
	localparam vt4_pkg::sum_t SatMin = vt4_pkg::SumW'(-64'sd2147483648);

	vt4_pkg::mat_t mat;
	vt4_pkg::stage_en_t en;
	vt4_pkg::sum_t sum_s3 [4];
	vt4_pkg::sum_t shifted [4];
	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic rdy1, rdy2, rdy3, rdy4;
	logic signed [vt4_pkg::FixW-1:0] comp [4];
	logic [3:0] sat;
	vt4_pkg::out_t res_s4;

	assign rdy4 = !valid_s4 || res_ready;
	assign rdy3 = !valid_s3 || rdy4;
	assign rdy2 = !valid_s2 || rdy3;
	assign rdy1 = !valid_s1 || rdy2;

	assign en.s1 = rdy1;
	assign en.s2 = rdy2;
	assign en.s3 = rdy3;

	assign vec_ready = rdy1;
	assign res_valid = valid_s4;
	assign res = res_s4;

	vt4_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_data (cfg_data),
		.mat      (mat)
	);

	for (genvar r = 0; r < 4; r++) begin : g_row
		vt4_row_dot u_dot (
			.clk    (clk),
			.en     (en),
			.row    (mat[r]),
			.vec    (vec),
			.sum_s3 (sum_s3[r])
		);

		assign shifted[r] = sum_s3[r] >>> FRAC_BITS;
	end

	always_comb begin
		for (int r = 0; r < 4; r++) begin
			priority if (shifted[r] > SatMax) begin
				comp[r] = SatMax[vt4_pkg::FixW-1:0];
				sat[r] = 1'b1;
			end else if (shifted[r] < SatMin) begin
				comp[r] = SatMin[vt4_pkg::FixW-1:0];
				sat[r] = 1'b1;
			end else begin
				comp[r] = shifted[r][vt4_pkg::FixW-1:0];
				sat[r] = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (rdy1) begin
				valid_s1 <= vec_valid;
			end
			if (rdy2) begin
				valid_s2 <= valid_s1;
			end
			if (rdy3) begin
				valid_s3 <= valid_s2;
			end
			if (rdy4) begin
				valid_s4 <= valid_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy4) begin
			res_s4.out_x <= comp[0];
			res_s4.out_y <= comp[1];
			res_s4.out_z <= comp[2];
			res_s4.out_w <= comp[3];
			res_s4.clipped <= |sat;
		end
	end

endmodule
